// ===== src/sbh_pkg.sv =====
package sbh_pkg;

  // Field widths
  localparam int IN_W       = 21;
  localparam int HEAD_W     = 16;
  localparam int LEN_W      = 12;
  localparam int BOX_W      = 10;
  localparam int RAD_W      = 12;
  localparam int ANGLE_BITS = 16;
  localparam int FRAC_BITS  = 4;
  localparam int FRAC_MASK  = (1 << FRAC_BITS) - 1;

  // Stream and configuration port widths
  localparam int IN_TDATA_W  = 112;
  localparam int OUT_TDATA_W = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 12;

  localparam logic [CFG_IDX_W-1:0] REG_BOX_SIZE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NEAR_RADIUS = 2'd1;

  localparam logic [BOX_W-1:0] BOX_SIZE_RST    = 10'd32;
  localparam logic [RAD_W-1:0] NEAR_RADIUS_RST = 12'd59;

  // Sine polynomial, Q15
  localparam int PB        = ANGLE_BITS - 2;
  localparam int ZSH       = (PB <= 15) ? (15 - PB) : (PB - 15);
  localparam int Z_W       = 16;
  localparam int S_W       = 16;
  localparam int OFS_MAG_W = LEN_W + S_W - 15 + FRAC_BITS;
  localparam int OFS_W     = OFS_MAG_W + 1;

  // Geometry
  localparam int E_W   = ((IN_W > OFS_W) ? IN_W : OFS_W) + 1;
  localparam int PX_W  = E_W - FRAC_BITS;
  localparam int CW    = PX_W + 2;
  localparam int DX_W  = PX_W + 1;
  localparam int CD_W  = CW + 1;
  localparam int CP_W  = CD_W + DX_W;
  localparam int V_W   = CP_W + 1;
  localparam int DA_W  = IN_W + 1;
  localparam int FX_W  = E_W + 1;
  localparam int DOT_W = DA_W + OFS_W + 1;
  localparam int LSQ_W = 2 * OFS_W + 1;
  localparam int DA2_W = 2 * DA_W + 1;
  localparam int DF2_W = 2 * FX_W + 1;
  localparam int CR_W  = DOT_W;
  localparam int M_W   = CR_W;
  localparam int LO_W  = (M_W + 1) / 2;
  localparam int HI_W  = M_W - LO_W;
  localparam int SQ_W  = 2 * M_W;
  localparam int RR_W  = 2 * RAD_W;
  localparam int RL_W  = RR_W + LSQ_W;

  // Pipeline depth
  localparam int N_STAGES = 12;

  // Orientation codes
  localparam logic [1:0] ORI_ZERO = 2'd0;
  localparam logic [1:0] ORI_POS  = 2'd1;
  localparam logic [1:0] ORI_NEG  = 2'd2;

  // Hand-over from the geometry stages to the decision stages.
  // Corners: 0 left/top, 1 right/top, 2 left/bottom, 3 right/bottom.
  // Edges: 0 top, 1 bottom, 2 left, 3 right.
  typedef struct packed {
    logic [3:0][CP_W-1:0] cpa;
    logic [3:0][CP_W-1:0] cpb;
    logic [3:0][1:0]      pcode;
    logic [3:0][1:0]      qcode;
    logic [DOT_W-1:0]     dot;
    logic [LSQ_W-1:0]     lsq;
    logic [DA2_W-1:0]     da2;
    logic [DF2_W-1:0]     df2;
    logic [CR_W-1:0]      cr;
    logic [RR_W-1:0]      rr;
  } geo_t;

endpackage

// ===== src/sbh_sincos.sv =====
module sbh_sincos (
  input  logic                                clk,
  input  logic [4:0]                          en,
  input  logic signed [sbh_pkg::IN_W-1:0]     start_x,
  input  logic signed [sbh_pkg::IN_W-1:0]     start_y,
  input  logic [sbh_pkg::HEAD_W-1:0]          heading,
  input  logic [sbh_pkg::LEN_W-1:0]           seg_length,
  input  logic signed [sbh_pkg::IN_W-1:0]     center_x,
  input  logic signed [sbh_pkg::IN_W-1:0]     center_y,
  output logic signed [sbh_pkg::IN_W-1:0]     sx,
  output logic signed [sbh_pkg::IN_W-1:0]     sy,
  output logic signed [sbh_pkg::IN_W-1:0]     cx,
  output logic signed [sbh_pkg::IN_W-1:0]     cy,
  output logic signed [sbh_pkg::OFS_W-1:0]    ox,
  output logic signed [sbh_pkg::OFS_W-1:0]    oy
);

  localparam int Z_W = sbh_pkg::Z_W;
  localparam int PB  = sbh_pkg::PB;
  localparam int ANGLE_BITS_W = sbh_pkg::ANGLE_BITS;
  localparam logic [Z_W-1:0] Q_ONE = 16'h8000;

  // Lane 0 is cosine (x), lane 1 is sine (y)
  logic signed [sbh_pkg::IN_W-1:0] sx_q [4];
  logic signed [sbh_pkg::IN_W-1:0] sy_q [4];
  logic signed [sbh_pkg::IN_W-1:0] cx_q [4];
  logic signed [sbh_pkg::IN_W-1:0] cy_q [4];
  logic [sbh_pkg::LEN_W-1:0]       len_q [4];

  logic [Z_W-1:0] z1 [2];
  logic [15:0]    zz1 [2];
  logic           ng1 [2];
  logic [Z_W-1:0] z2 [2];
  logic [15:0]    zz2 [2];
  logic [14:0]    t1 [2];
  logic           ng2 [2];
  logic [Z_W-1:0] z3 [2];
  logic [15:0]    t2 [2];
  logic           ng3 [2];
  logic [sbh_pkg::S_W-1:0] s4 [2];
  logic                    ng4 [2];

  logic [ANGLE_BITS_W-1:0] hq;

  logic [PB-1:0]   ph;
  logic [1:0]      quad;
  logic [1:0]      qd [2];
  logic [Z_W-1:0]  z0;
  logic [Z_W-1:0]  zn [2];
  logic [2*Z_W-1:0] zsq [2];
  logic [27:0]     p2 [2];
  logic [30:0]     p3 [2];
  logic [31:0]     p4 [2];
  logic [27:0]     p5 [2];
  logic [sbh_pkg::OFS_MAG_W-1:0] mag [2];
  logic signed [sbh_pkg::OFS_W-1:0] ofs [2];

  // Split the angle into quadrant and phase, scale phase to Q15
  always_comb begin
    hq   = heading[ANGLE_BITS_W-1:0];
    quad = hq[ANGLE_BITS_W-1 -: 2];
    ph   = hq[PB-1:0];
    z0   = (PB <= 15) ? (Z_W'(ph) << sbh_pkg::ZSH) : Z_W'(ph >> sbh_pkg::ZSH);
    qd[1] = quad;
    qd[0] = quad + 2'd1;
    for (int l = 0; l < 2; l++) begin
      zn[l]  = qd[l][0] ? (Q_ONE - z0) : z0;
      zsq[l] = zn[l] * zn[l];
    end
  end

  // Polynomial steps, one product per stage
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      p2[l]  = 28'(zz1[l]) * 28'd2320;
      p3[l]  = 31'(t1[l]) * 31'(zz2[l]);
      p4[l]  = 32'(t2[l]) * 32'(z3[l]);
      p5[l]  = 28'(len_q[3]) * 28'(s4[l]);
      mag[l] = p5[l][27 -: sbh_pkg::OFS_MAG_W];
      ofs[l] = ng4[l] ? -sbh_pkg::OFS_W'(mag[l]) : sbh_pkg::OFS_W'(mag[l]);
    end
  end

  // Stage 1: z and z squared
  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int l = 0; l < 2; l++) begin
        z1[l]  <= zn[l];
        zz1[l] <= zsq[l][30:15];
        ng1[l] <= qd[l][1];
      end
      sx_q[0]  <= start_x;
      sy_q[0]  <= start_y;
      cx_q[0]  <= center_x;
      cy_q[0]  <= center_y;
      len_q[0] <= seg_length;
    end
  end

  // Stage 2: first coefficient
  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int l = 0; l < 2; l++) begin
        z2[l]  <= z1[l];
        zz2[l] <= zz1[l];
        t1[l]  <= 15'd21024 - 15'(p2[l][27:15]);
        ng2[l] <= ng1[l];
      end
      sx_q[1]  <= sx_q[0];
      sy_q[1]  <= sy_q[0];
      cx_q[1]  <= cx_q[0];
      cy_q[1]  <= cy_q[0];
      len_q[1] <= len_q[0];
    end
  end

  // Stage 3: second coefficient
  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int l = 0; l < 2; l++) begin
        z3[l]  <= z2[l];
        t2[l]  <= 16'd51472 - p3[l][30:15];
        ng3[l] <= ng2[l];
      end
      sx_q[2]  <= sx_q[1];
      sy_q[2]  <= sy_q[1];
      cx_q[2]  <= cx_q[1];
      cy_q[2]  <= cy_q[1];
      len_q[2] <= len_q[1];
    end
  end

  // Stage 4: sine magnitude
  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int l = 0; l < 2; l++) begin
        s4[l]  <= p4[l][30:15];
        ng4[l] <= ng3[l];
      end
      sx_q[3]  <= sx_q[2];
      sy_q[3]  <= sy_q[2];
      cx_q[3]  <= cx_q[2];
      cy_q[3]  <= cy_q[2];
      len_q[3] <= len_q[2];
    end
  end

  // Stage 5: scaled offsets, truncated toward zero
  always_ff @(posedge clk) begin
    if (en[4]) begin
      ox <= ofs[0];
      oy <= ofs[1];
      sx <= sx_q[3];
      sy <= sy_q[3];
      cx <= cx_q[3];
      cy <= cy_q[3];
    end
  end

endmodule

// ===== src/sbh_geom.sv =====
module sbh_geom (
  input  logic                              clk,
  input  logic [3:0]                        en,
  input  logic [sbh_pkg::BOX_W-1:0]         box_size,
  input  logic [sbh_pkg::RAD_W-1:0]         near_radius,
  input  logic signed [sbh_pkg::IN_W-1:0]   sx,
  input  logic signed [sbh_pkg::IN_W-1:0]   sy,
  input  logic signed [sbh_pkg::IN_W-1:0]   cx,
  input  logic signed [sbh_pkg::IN_W-1:0]   cy,
  input  logic signed [sbh_pkg::OFS_W-1:0]  ox,
  input  logic signed [sbh_pkg::OFS_W-1:0]  oy,
  output sbh_pkg::geo_t                     geo
);

  localparam int E_W  = sbh_pkg::E_W;
  localparam int PX_W = sbh_pkg::PX_W;
  localparam int CW   = sbh_pkg::CW;

  // Truncate toward zero to whole pixels
  function automatic logic signed [PX_W-1:0] to_px(input logic signed [E_W-1:0] q);
    logic signed [E_W-1:0] b;
    b = q + (q[E_W-1] ? E_W'(sbh_pkg::FRAC_MASK) : E_W'(0));
    return PX_W'(b >>> sbh_pkg::FRAC_BITS);
  endfunction

  // Side of a point against an edge line
  function automatic logic [1:0] hside(input logic signed [CW-1:0] a,
                                       input logic signed [CW-1:0] e);
    logic [1:0] c;
    if (a < e) c = sbh_pkg::ORI_POS;
    else if (a > e) c = sbh_pkg::ORI_NEG;
    else c = sbh_pkg::ORI_ZERO;
    return c;
  endfunction

  // Stage 6 registers
  logic signed [E_W-1:0]           ex6, ey6;
  logic signed [sbh_pkg::DA_W-1:0] a6, b6;
  logic signed [PX_W-1:0]          px6, py6, cpx6, cpy6;
  logic signed [sbh_pkg::OFS_W-1:0] ox6, oy6;
  logic signed [sbh_pkg::IN_W-1:0]  cx6, cy6;

  // Stage 7 registers
  logic signed [PX_W-1:0]          px7, py7, qx7, qy7;
  logic signed [CW-1:0]            l7, t7, r7, b7;
  logic signed [sbh_pkg::FX_W-1:0] fx7, fy7;
  logic signed [sbh_pkg::DA_W-1:0] a7, b7d;
  logic signed [sbh_pkg::OFS_W-1:0] ox7, oy7;

  // Stage 8 registers
  logic signed [sbh_pkg::DX_W-1:0] dxs8, dys8;
  logic signed [sbh_pkg::CD_W-1:0] cdl8, cdr8, cdt8, cdb8;
  logic [3:0][1:0]                 pc8, qc8;
  logic signed [sbh_pkg::DA_W+sbh_pkg::OFS_W-1:0] ac8, bd8, ad8, bc8;
  logic signed [2*sbh_pkg::OFS_W-1:0] cc8, dd8;
  logic signed [2*sbh_pkg::DA_W-1:0]  aa8, bb8;
  logic signed [2*sbh_pkg::FX_W-1:0]  ff8, gg8;
  logic [sbh_pkg::RR_W-1:0]           rr8;

  logic [sbh_pkg::BOX_W-1:0] half;
  logic [sbh_pkg::BOX_W-1:0] rest;
  logic                      box_zero;
  logic signed [CW-1:0]      qxw, qyw, pxw, pyw;
  logic [3:0][1:0]           pc_n, qc_n;

  assign half     = box_size >> 1;
  assign rest     = box_size - half;
  assign box_zero = (box_size == '0);
  assign qxw      = CW'(qx7);
  assign qyw      = CW'(qy7);
  assign pxw      = CW'(px7);
  assign pyw      = CW'(py7);

  // Side codes of both segment ends against each edge line, all zero when box_size is zero
  always_comb begin
    pc_n[0] = hside(pyw, t7);
    pc_n[1] = hside(pyw, b7);
    pc_n[2] = hside(l7, pxw);
    pc_n[3] = hside(r7, pxw);
    qc_n[0] = hside(qyw, t7);
    qc_n[1] = hside(qyw, b7);
    qc_n[2] = hside(l7, qxw);
    qc_n[3] = hside(r7, qxw);
    if (box_zero) begin
      pc_n = '0;
      qc_n = '0;
    end
  end

  // Stage 6: end point, start-to-centre vector, pixel start and centre
  always_ff @(posedge clk) begin
    if (en[0]) begin
      ex6  <= E_W'(sx) + E_W'(ox);
      ey6  <= E_W'(sy) + E_W'(oy);
      a6   <= sbh_pkg::DA_W'(cx) - sbh_pkg::DA_W'(sx);
      b6   <= sbh_pkg::DA_W'(cy) - sbh_pkg::DA_W'(sy);
      px6  <= to_px(E_W'(sx));
      py6  <= to_px(E_W'(sy));
      cpx6 <= to_px(E_W'(cx));
      cpy6 <= to_px(E_W'(cy));
      ox6  <= ox;
      oy6  <= oy;
      cx6  <= cx;
      cy6  <= cy;
    end
  end

  // Stage 7: pixel end point, box edges, end-to-centre vector
  always_ff @(posedge clk) begin
    if (en[1]) begin
      qx7 <= to_px(ex6);
      qy7 <= to_px(ey6);
      l7  <= CW'(cpx6) - CW'(half);
      t7  <= CW'(cpy6) - CW'(half);
      r7  <= CW'(cpx6) + CW'(rest);
      b7  <= CW'(cpy6) + CW'(rest);
      fx7 <= sbh_pkg::FX_W'(cx6) - sbh_pkg::FX_W'(ex6);
      fy7 <= sbh_pkg::FX_W'(cy6) - sbh_pkg::FX_W'(ey6);
      px7 <= px6;
      py7 <= py6;
      a7  <= a6;
      b7d <= b6;
      ox7 <= ox6;
      oy7 <= oy6;
    end
  end

  // Stage 8: segment and corner differences, closeness products
  always_ff @(posedge clk) begin
    if (en[2]) begin
      dxs8 <= sbh_pkg::DX_W'(qx7) - sbh_pkg::DX_W'(px7);
      dys8 <= sbh_pkg::DX_W'(qy7) - sbh_pkg::DX_W'(py7);
      cdl8 <= sbh_pkg::CD_W'(l7) - sbh_pkg::CD_W'(qxw);
      cdr8 <= sbh_pkg::CD_W'(r7) - sbh_pkg::CD_W'(qxw);
      cdt8 <= sbh_pkg::CD_W'(t7) - sbh_pkg::CD_W'(qyw);
      cdb8 <= sbh_pkg::CD_W'(b7) - sbh_pkg::CD_W'(qyw);
      pc8  <= pc_n;
      qc8  <= qc_n;
      ac8  <= a7 * ox7;
      bd8  <= b7d * oy7;
      ad8  <= a7 * oy7;
      bc8  <= b7d * ox7;
      cc8  <= ox7 * ox7;
      dd8  <= oy7 * oy7;
      aa8  <= a7 * a7;
      bb8  <= b7d * b7d;
      ff8  <= fx7 * fx7;
      gg8  <= fy7 * fy7;
      rr8  <= sbh_pkg::RR_W'(near_radius) * sbh_pkg::RR_W'(near_radius);
    end
  end

  logic signed [sbh_pkg::CP_W-1:0] cpa_n [4];
  logic signed [sbh_pkg::CP_W-1:0] cpb_n [4];

  // Corner orientation products against the segment
  always_comb begin
    cpa_n[0] = dys8 * cdl8;
    cpa_n[1] = dys8 * cdr8;
    cpa_n[2] = dys8 * cdl8;
    cpa_n[3] = dys8 * cdr8;
    cpb_n[0] = dxs8 * cdt8;
    cpb_n[1] = dxs8 * cdt8;
    cpb_n[2] = dxs8 * cdb8;
    cpb_n[3] = dxs8 * cdb8;
  end

  // Stage 9: corner products and closeness sums
  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int k = 0; k < 4; k++) begin
        geo.cpa[k] <= cpa_n[k];
        geo.cpb[k] <= cpb_n[k];
      end
      geo.pcode <= pc8;
      geo.qcode <= qc8;
      geo.dot   <= sbh_pkg::DOT_W'(ac8) + sbh_pkg::DOT_W'(bd8);
      geo.lsq   <= sbh_pkg::LSQ_W'(cc8) + sbh_pkg::LSQ_W'(dd8);
      geo.da2   <= sbh_pkg::DA2_W'(aa8) + sbh_pkg::DA2_W'(bb8);
      geo.df2   <= sbh_pkg::DF2_W'(ff8) + sbh_pkg::DF2_W'(gg8);
      geo.cr    <= sbh_pkg::CR_W'(ad8) - sbh_pkg::CR_W'(bc8);
      geo.rr    <= rr8;
    end
  end

endmodule

// ===== src/sbh_decide.sv =====
module sbh_decide (
  input  logic          clk,
  input  logic [2:0]    en,
  input  sbh_pkg::geo_t geo,
  output logic          hit,
  output logic          near
);

  localparam int M_W  = sbh_pkg::M_W;
  localparam int LO_W = sbh_pkg::LO_W;
  localparam int HI_W = sbh_pkg::HI_W;

  // Stage 10 registers
  logic [3:0][1:0]           oc10, pc10, qc10;
  logic [M_W-1:0]            m10;
  logic                      cs10, ce10, na10, nf10;
  logic [sbh_pkg::RR_W-1:0]  rr10;
  logic [sbh_pkg::LSQ_W-2:0] lsq10;

  // Stage 11 registers
  logic                      cs11, ce11, na11, nf11;
  logic [2*HI_W-1:0]         hh11;
  logic [HI_W+LO_W-1:0]      hl11;
  logic [2*LO_W-1:0]         ll11;
  logic [sbh_pkg::RL_W-1:0]  rl11;
  logic                      hit11;

  logic signed [sbh_pkg::V_W-1:0] v [4];
  logic [3:0][1:0]                oc_n;
  logic signed [sbh_pkg::DOT_W-1:0] dot_s;
  logic signed [sbh_pkg::LSQ_W-1:0] lsq_s;
  logic signed [sbh_pkg::CR_W-1:0]  cr_s;
  logic [3:0]                       crossed;
  logic [sbh_pkg::SQ_W-1:0]         msq;

  assign dot_s = $signed(geo.dot);
  assign lsq_s = $signed(geo.lsq);
  assign cr_s  = $signed(geo.cr);

  // Corner orientation codes
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      v[k] = sbh_pkg::V_W'($signed(geo.cpa[k])) - sbh_pkg::V_W'($signed(geo.cpb[k]));
      if (v[k] == '0) oc_n[k] = sbh_pkg::ORI_ZERO;
      else if (v[k] > 0) oc_n[k] = sbh_pkg::ORI_POS;
      else oc_n[k] = sbh_pkg::ORI_NEG;
    end
  end

  // Stage 10: orientation codes, region of the closest point
  always_ff @(posedge clk) begin
    if (en[0]) begin
      oc10  <= oc_n;
      pc10  <= geo.pcode;
      qc10  <= geo.qcode;
      m10   <= cr_s[sbh_pkg::CR_W-1] ? M_W'(-cr_s) : M_W'(cr_s);
      cs10  <= (geo.lsq == '0) || dot_s[sbh_pkg::DOT_W-1];
      ce10  <= dot_s > sbh_pkg::DOT_W'(lsq_s);
      na10  <= geo.da2 < sbh_pkg::DA2_W'(geo.rr);
      nf10  <= geo.df2 < sbh_pkg::DF2_W'(geo.rr);
      rr10  <= geo.rr;
      lsq10 <= geo.lsq[sbh_pkg::LSQ_W-2:0];
    end
  end

  // Edge crossings: top, bottom, left, right
  always_comb begin
    crossed[0] = (oc10[0] != oc10[1]) && (pc10[0] != qc10[0]);
    crossed[1] = (oc10[2] != oc10[3]) && (pc10[1] != qc10[1]);
    crossed[2] = (oc10[0] != oc10[2]) && (pc10[2] != qc10[2]);
    crossed[3] = (oc10[1] != oc10[3]) && (pc10[3] != qc10[3]);
  end

  // Stage 11: hit, partial products of the squared cross term
  always_ff @(posedge clk) begin
    if (en[1]) begin
      hit11 <= |crossed;
      hh11  <= m10[M_W-1 -: HI_W] * m10[M_W-1 -: HI_W];
      hl11  <= (HI_W+LO_W)'(m10[M_W-1 -: HI_W]) * (HI_W+LO_W)'(m10[LO_W-1:0]);
      ll11  <= m10[LO_W-1:0] * m10[LO_W-1:0];
      rl11  <= sbh_pkg::RL_W'(rr10) * sbh_pkg::RL_W'(lsq10);
      cs11  <= cs10;
      ce11  <= ce10;
      na11  <= na10;
      nf11  <= nf10;
    end
  end

  assign msq = (sbh_pkg::SQ_W'(hh11) << (2 * LO_W))
             + (sbh_pkg::SQ_W'(hl11) << (LO_W + 1))
             + sbh_pkg::SQ_W'(ll11);

  // Stage 12: pick the closeness answer for the region
  always_ff @(posedge clk) begin
    if (en[2]) begin
      hit <= hit11;
      if (cs11) near <= na11;
      else if (ce11) near <= nf11;
      else near <= msq < sbh_pkg::SQ_W'(rl11);
    end
  end

endmodule

// ===== src/segment_box_hit_test_unit.sv =====
// Throughput: one beat per cycle while the output is not stalled; twelve
// register stages, each holding at most one multiplier level, with a valid
// bit per stage.
// A stalled stage holds; empty stages ahead of it still fill.
// Reset: synchronous, clears all stage valid bits and loads box_size 32
// and near_radius 59; the configuration channel is always ready.
module segment_box_hit_test_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // start_x, start_y, heading, seg_length, center_x, center_y
  input  logic [sbh_pkg::IN_TDATA_W-1:0]     s_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // hit, near, zero fill
  output logic [sbh_pkg::OUT_TDATA_W-1:0]    m_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [sbh_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sbh_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int N = sbh_pkg::N_STAGES;

  logic [sbh_pkg::BOX_W-1:0] box_size;
  logic [sbh_pkg::RAD_W-1:0] near_radius;
  logic [N-1:0]              v;
  logic [N:0]                rdy;
  logic [N-1:0]              vin;

  logic signed [sbh_pkg::IN_W-1:0]  sx, sy, cx, cy;
  logic signed [sbh_pkg::OFS_W-1:0] ox, oy;
  sbh_pkg::geo_t                    geo;
  logic                             hit, near;

  // Configuration writes
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      box_size    <= sbh_pkg::BOX_SIZE_RST;
      near_radius <= sbh_pkg::NEAR_RADIUS_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        sbh_pkg::REG_BOX_SIZE:    box_size <= cfg_data[sbh_pkg::BOX_W-1:0];
        sbh_pkg::REG_NEAR_RADIUS: near_radius <= cfg_data[sbh_pkg::RAD_W-1:0];
        default: ;
      endcase
    end
  end

  // A stage advances when empty or when the stage after it advances
  always_comb begin
    rdy[N] = m_tready;
    for (int k = N - 1; k >= 0; k--) begin
      rdy[k] = !v[k] || rdy[k+1];
    end
  end

  assign vin = {v[N-2:0], s_tvalid};

  always_ff @(posedge clk) begin
    if (rst) v <= '0;
    else v <= (rdy[N-1:0] & vin) | (~rdy[N-1:0] & v);
  end

  assign s_tready = rdy[0];
  assign m_tvalid = v[N-1];
  assign m_tdata  = {6'd0, near, hit};

  sbh_sincos u_sincos (
    .clk        (clk),
    .en         (rdy[4:0]),
    .start_x    (s_tdata[20:0]),
    .start_y    (s_tdata[41:21]),
    .heading    (s_tdata[57:42]),
    .seg_length (s_tdata[69:58]),
    .center_x   (s_tdata[90:70]),
    .center_y   (s_tdata[111:91]),
    .sx         (sx),
    .sy         (sy),
    .cx         (cx),
    .cy         (cy),
    .ox         (ox),
    .oy         (oy)
  );

  sbh_geom u_geom (
    .clk         (clk),
    .en          (rdy[8:5]),
    .box_size    (box_size),
    .near_radius (near_radius),
    .sx          (sx),
    .sy          (sy),
    .cx          (cx),
    .cy          (cy),
    .ox          (ox),
    .oy          (oy),
    .geo         (geo)
  );

  sbh_decide u_decide (
    .clk  (clk),
    .en   (rdy[11:9]),
    .geo  (geo),
    .hit  (hit),
    .near (near)
  );

endmodule
